// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bubble sort engine: the input and
// output word layouts and the element width.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam int unsigned ELEM_W = 32;

  // One input word: an element and the end-of-set flag
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } in_word_t;

  // One output word: a sorted element and the end-of-set flag
  typedef struct packed {
    logic signed [ELEM_W-1:0] sorted_value;
    logic                     final_res;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/bse_cmp.sv =====
// ----------------------------------------------------------------------------
// bse_cmp
// Shared compare unit: decides whether an adjacent pair is out of order
// for the selected direction. Equal values never swap.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_cmp
  import bse_pkg::*;
(
  input  wire logic signed [ELEM_W-1:0] left,
  input  wire logic signed [ELEM_W-1:0] right,
  input  wire logic                     desc,
  output logic                          swap
);

  // Swap on strict inequality only
  always_comb begin
    if (desc) begin
      swap = (right > left);
    end else begin
      swap = (left > right);
    end
  end

endmodule

`default_nettype wire

// ===== sv/bubble_sort_engine.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Buffers a set of signed elements, bubble sorts them in place in a
// single-port-write memory with one shared compare unit, then streams
// the sorted set out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one element per word;
//   in_data.last closes the set. While loading, a word is taken every cycle.
//   Words beyond CAPACITY are dropped; a dropped word flagged last still
//   closes the set.
//   Output channel (out_valid / out_stall / out_data): the sorted set in
//   order, out_data.final_res set on its last word.
//   cfg_we / cfg_wdata write the order bit (1 = descending); it is sampled
//   when the closing word is taken.
// Phases, for a set of n elements:
//   sort: n-1 passes over the element memory, one compare and one memory
//   write per cycle while stepping through a pass; skipped when n < 2.
//   emit: each word passes the registered memory read, then the output
//   register; the next read waits until the previous one has returned.
//   in_stall is high from the closing word until the last read of the emit
//   phase; loading of the next set overlaps the final output word.
// Reset: synchronous rst empties the set, clears the order bit to ascending
//   and drops any output word. Memory contents are not cleared.
// Stall: a stalled output word holds; emission pauses until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_sort_engine
  import bse_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_FIRST,
    ST_STEP,
    ST_WB,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         pass;
  logic [IDX_W-1:0]         emit_idx;
  logic signed [ELEM_W-1:0] cur;
  logic                     descending;
  logic                     desc_sort;
  logic                     rd_pend;
  logic                     rd_final;
  logic                     swap;
  logic                     in_take;
  logic                     emit_issue;

  // Element memory ports
  logic signed [ELEM_W-1:0] mem [CAPACITY];
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [ELEM_W-1:0] wr_data;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [ELEM_W-1:0] rd_data;

  assign in_stall   = (state != ST_LOAD);
  assign in_take    = in_valid && !in_stall;
  assign last_idx   = IDX_W'(count - 1'b1);
  assign emit_issue = (state == ST_EMIT) && !rd_pend && (!out_valid || !out_stall);

  // Count after the word taken this cycle, if any room is left
  always_comb begin
    if (count < CAP_CNT) begin
      count_next = CNT_W'(count + 1'b1);
    end else begin
      count_next = count;
    end
  end

  // Shared compare: carried element against the element just read
  bse_cmp u_cmp (
    .left  (cur),
    .right (rd_data),
    .desc  (desc_sort),
    .swap  (swap)
  );

  // Drive memory write and read ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur;
    rd_addr = '0;
    unique case (state)
      ST_LOAD: begin
        wr_en   = in_take && (count < CAP_CNT);
        wr_addr = count[IDX_W-1:0];
        wr_data = in_data.value;
      end
      ST_FETCH: begin
        rd_addr = '0;
      end
      ST_FIRST: begin
        rd_addr = IDX_W'(1);
      end
      ST_STEP: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(idx - 1'b1);
        wr_data = swap ? rd_data : cur;
        rd_addr = IDX_W'(idx + 1'b1);
      end
      ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = last_idx;
        wr_data = cur;
        rd_addr = '0;
      end
      ST_EMIT: begin
        rd_addr = emit_idx;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Element memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_we) begin
      descending <= cfg_wdata;
    end
  end

  // Sequencer: load, sort passes, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      idx       <= '0;
      pass      <= '0;
      emit_idx  <= '0;
      desc_sort <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= emit_issue;

      // Output register: load on read return, drop when taken
      if (rd_pend) begin
        out_valid             <= 1'b1;
        out_data.sorted_value <= rd_data;
        out_data.final_res    <= rd_final;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            count <= count_next;
            if (in_data.last) begin
              desc_sort <= descending;
              pass      <= '0;
              emit_idx  <= '0;
              if (count_next < TWO_CNT) begin
                state <= ST_EMIT;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_FETCH: begin
          state <= ST_FIRST;
        end
        ST_FIRST: begin
          idx   <= IDX_W'(1);
          state <= ST_STEP;
        end
        ST_STEP: begin
          idx <= IDX_W'(idx + 1'b1);
          if (idx == last_idx) begin
            pass  <= IDX_W'(pass + 1'b1);
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (pass == last_idx) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_FIRST;
          end
        end
        ST_EMIT: begin
          if (emit_issue) begin
            emit_idx <= IDX_W'(emit_idx + 1'b1);
            if (emit_idx == last_idx) begin
              count <= '0;
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Carried element and end-of-set flag of the pending read
  always_ff @(posedge clk) begin
    if (state == ST_FIRST) begin
      cur <= rd_data;
    end else if (state == ST_STEP && !swap) begin
      cur <= rd_data;
    end
    if (emit_issue) begin
      rd_final <= (emit_idx == last_idx);
    end
  end

`ifndef SYNTHESIS
  // Fill level never passes capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("element count above capacity");

  // Sort passes only run on sets of two or more
  a_sort_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP || state == ST_WB || state == ST_FIRST) |-> count >= TWO_CNT)
    else $error("sort pass on a set smaller than two");

  // Emit phase always has at least one element
  a_emit_size: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> count != '0)
    else $error("emit phase with an empty set");

  // A returning read always lands in the output register
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("memory read lost before output register");
`endif

endmodule

`default_nettype wire
